### rtl/rap_pkg.sv
// Retry-After parser package: phase type, limits, verdict struct and the
// seconds-to-milliseconds scaling function. No dependencies.
package rap_pkg;

  localparam int SecW  = 40;
  localparam int WaitW = 50;

  localparam logic [SecW-1:0]  SEC_LIMIT   = 40'd1000000000000;
  localparam logic [WaitW-1:0] WAIT_SAT_MS = 50'd1000000000000000;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_DIGITS,
    PH_TRAIL,
    PH_ERROR
  } phase_t;

  // Outcome of one finished header value, before scaling.
  typedef struct packed {
    logic            ok;
    logic            sat;
    logic [SecW-1:0] seconds;
  } verdict_t;

  // seconds * 1000 as (s << 10) - (s << 4) - (s << 3); saturate, or zero when invalid.
  function automatic logic [WaitW-1:0] to_ms(verdict_t v);
    logic [WaitW-1:0] s;
    logic [WaitW-1:0] ms;
    s  = {{(WaitW-SecW){1'b0}}, v.seconds};
    ms = (s << 10) - (s << 4) - (s << 3);
    if (!v.ok) begin
      return '0;
    end else if (v.sat) begin
      return WAIT_SAT_MS;
    end
    return ms;
  endfunction

endpackage

### rtl/rap_if.sv
// Valid/ready channel interfaces for the Retry-After parser.
// Depends on nothing; the payload widths are fixed by the header format.
interface rap_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_byte;
  logic       empty_value;

  modport source (output valid, output byte_in, output last_byte, output empty_value,
                  input ready);
  modport sink   (input valid, input byte_in, input last_byte, input empty_value,
                  output ready);
endinterface

interface rap_out_if;
  logic        valid;
  logic        ready;
  logic        is_valid;
  logic [49:0] wait_ms;

  modport source (output valid, output is_valid, output wait_ms, input ready);
  modport sink   (input valid, input is_valid, input wait_ms, output ready);
endinterface

### rtl/retry_after_seconds_parser.sv
// Top level of the Retry-After delta-seconds parser.
// Depends on rap_pkg, rap_if (rap_in_if, rap_out_if) and rap_scan.
//
// Usage:
//   hdr carries the header value one byte per item; last_byte marks the final
//   byte, and empty_value ends the value without consuming its byte (an
//   absent or zero-length value, or a value cut short).
//   res carries one item per finished value: is_valid, and wait_ms equal to
//   the seconds times 1000, saturated at 10^15, or 0 when is_valid is 0.
//   Bytes that do not end a value produce no result item.
// Timing:
//   One byte is taken per cycle unless res stalls, with no gaps between
//   values. A result reaches res through two registers after its closing
//   byte is accepted: one holds the verdict, the next holds the scaled wait.
// Reset (rst, synchronous): scanner returns to leading whitespace with a
//   cleared accumulator; both result stages are emptied.
// Stall: while res.ready is low the two result stages fill; hdr.ready drops
//   only once both are full, and returns in the cycle res.ready rises.
module retry_after_seconds_parser (
  input  logic       clk,
  input  logic       rst,
  rap_in_if.sink     hdr,
  rap_out_if.source  res
);

  logic              hdr_fire;
  logic              emit;
  rap_pkg::verdict_t verdict;

  rap_pkg::verdict_t mid;
  logic              mid_valid;
  logic              mid_adv;
  logic              out_adv;

  logic                       out_is_valid;
  logic [rap_pkg::WaitW-1:0]  out_wait_ms;
  logic                       out_valid;

  assign out_adv   = !out_valid || res.ready;
  assign mid_adv   = !mid_valid || out_adv;
  assign hdr.ready = mid_adv;
  assign hdr_fire  = hdr.valid && hdr.ready;

  rap_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .fire        (hdr_fire),
    .byte_in     (hdr.byte_in),
    .last_byte   (hdr.last_byte),
    .empty_value (hdr.empty_value),
    .emit        (emit),
    .verdict     (verdict)
  );

  // Verdict stage
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (mid_adv) begin
      mid_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_adv && emit) begin
      mid <= verdict;
    end
  end

  // Result stage: scale to milliseconds
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && mid_valid) begin
      out_is_valid <= mid.ok;
      out_wait_ms  <= rap_pkg::to_ms(mid);
    end
  end

  assign res.valid    = out_valid;
  assign res.is_valid = out_is_valid;
  assign res.wait_ms  = out_wait_ms;

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.is_valid |-> res.wait_ms == '0)
    else $error("invalid result carries a nonzero wait");

  a_wait_bound: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.wait_ms <= rap_pkg::WAIT_SAT_MS)
    else $error("wait exceeds saturation value");

  a_empty_emits: assert property (@(posedge clk) disable iff (rst)
    hdr_fire && hdr.empty_value |=> mid_valid)
    else $error("empty value did not produce a verdict");

  a_mid_moves: assert property (@(posedge clk) disable iff (rst)
    mid_valid && out_adv |=> out_valid)
    else $error("verdict lost between stages");

endmodule

### rtl/rap_scan.sv
// Byte scanner: phase machine and seconds accumulator for one header value.
// Depends on rap_pkg.
module rap_scan (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [7:0]          byte_in,
  input  logic                last_byte,
  input  logic                empty_value,
  output logic                emit,
  output rap_pkg::verdict_t   verdict
);

  rap_pkg::phase_t              phase;
  rap_pkg::phase_t              phase_next;
  logic [rap_pkg::SecW-1:0]     seconds_acc;
  logic [rap_pkg::SecW-1:0]     seconds_acc_next;
  logic                         too_large;
  logic                         too_large_next;

  logic                         is_dig;
  logic                         is_ws;
  logic                         take;
  logic [3:0]                   digit;
  logic [rap_pkg::SecW+3:0]     acc_x10;

  assign is_dig = (byte_in >= rap_pkg::CH_ZERO) && (byte_in <= rap_pkg::CH_NINE);
  assign is_ws  = (byte_in == rap_pkg::CH_SPACE) || (byte_in == rap_pkg::CH_TAB);
  assign digit  = 4'(byte_in - rap_pkg::CH_ZERO);
  assign take   = is_dig && ((phase == rap_pkg::PH_LEAD) || (phase == rap_pkg::PH_DIGITS));
  assign emit   = fire && (empty_value || last_byte);

  // acc * 10 + digit, wide enough to never wrap
  assign acc_x10 = ({4'b0, seconds_acc} << 3) + ({4'b0, seconds_acc} << 1)
                 + {{rap_pkg::SecW{1'b0}}, digit};

  // Phase after this byte.
  always_comb begin
    phase_next = phase;
    unique case (phase)
      rap_pkg::PH_LEAD: begin
        if (is_dig) begin
          phase_next = rap_pkg::PH_DIGITS;
        end else if (!is_ws) begin
          phase_next = rap_pkg::PH_ERROR;
        end
      end
      rap_pkg::PH_DIGITS: begin
        if (is_ws) begin
          phase_next = rap_pkg::PH_TRAIL;
        end else if (!is_dig) begin
          phase_next = rap_pkg::PH_ERROR;
        end
      end
      rap_pkg::PH_TRAIL: begin
        if (!is_ws) begin
          phase_next = rap_pkg::PH_ERROR;
        end
      end
      default: phase_next = rap_pkg::PH_ERROR;
    endcase
  end

  // Accumulator after this byte and the verdict for a value that ends now.
  always_comb begin
    seconds_acc_next = seconds_acc;
    too_large_next   = too_large;
    if (take && !too_large) begin
      if (acc_x10 > {4'b0, rap_pkg::SEC_LIMIT}) begin
        too_large_next = 1'b1;
      end else begin
        seconds_acc_next = acc_x10[rap_pkg::SecW-1:0];
      end
    end
    // empty flag ends the value without consuming the byte
    if (empty_value) begin
      verdict.ok      = (phase == rap_pkg::PH_DIGITS) || (phase == rap_pkg::PH_TRAIL);
      verdict.sat     = too_large;
      verdict.seconds = seconds_acc;
    end else begin
      verdict.ok      = (phase_next == rap_pkg::PH_DIGITS) ||
                        (phase_next == rap_pkg::PH_TRAIL);
      verdict.sat     = too_large_next;
      verdict.seconds = seconds_acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || emit) begin
      phase       <= rap_pkg::PH_LEAD;
      seconds_acc <= '0;
      too_large   <= 1'b0;
    end else if (fire) begin
      phase       <= phase_next;
      seconds_acc <= seconds_acc_next;
      too_large   <= too_large_next;
    end
  end

endmodule

### tb/retry_after_seconds_parser_checker.sv
`timescale 1ns / 100ps
// Checker for the Retry-After parser: watches both channels, predicts each result
// item from the accepted header bytes and compares. Depends on rap_pkg.
module retry_after_seconds_parser_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      hdr_valid,
  input  logic                      hdr_ready,
  input  logic [7:0]                hdr_byte,
  input  logic                      hdr_last,
  input  logic                      hdr_empty,
  input  logic                      res_valid,
  input  logic                      res_ready,
  input  logic                      res_is_valid,
  input  logic [rap_pkg::WaitW-1:0] res_wait_ms,
  output int                        fail_count,
  output int                        pending
);

  typedef struct packed {
    rap_pkg::phase_t          ph;
    logic [rap_pkg::SecW-1:0] secs;
    logic                     big;
  } scan_t;

  typedef struct packed {
    logic                      is_valid;
    logic [rap_pkg::WaitW-1:0] wait_ms;
  } wait_res_t;

  localparam scan_t ScanIdle = '{ph: rap_pkg::PH_LEAD, secs: '0, big: 1'b0};

  scan_t     scan = ScanIdle;
  wait_res_t waits_due[$];
  wait_res_t want;
  int        errs = 0;

  function automatic scan_t scan_byte(scan_t s, logic [7:0] c);
    scan_t                    n;
    logic                     ws;
    logic                     dig;
    logic [rap_pkg::SecW+3:0] grown;
    n   = s;
    ws  = (c == rap_pkg::CH_SPACE) || (c == rap_pkg::CH_TAB);
    dig = (c >= rap_pkg::CH_ZERO) && (c <= rap_pkg::CH_NINE);
    case (s.ph)
      rap_pkg::PH_LEAD: begin
        if (dig) n.ph = rap_pkg::PH_DIGITS;
        else if (!ws) n.ph = rap_pkg::PH_ERROR;
      end
      rap_pkg::PH_DIGITS: begin
        if (ws) n.ph = rap_pkg::PH_TRAIL;
        else if (!dig) n.ph = rap_pkg::PH_ERROR;
      end
      rap_pkg::PH_TRAIL: begin
        if (!ws) n.ph = rap_pkg::PH_ERROR;
      end
      default: n.ph = rap_pkg::PH_ERROR;
    endcase
    // Accumulate only digits taken while still in the number; freeze once past the cap.
    if (dig && (s.ph == rap_pkg::PH_LEAD || s.ph == rap_pkg::PH_DIGITS) && !s.big) begin
      grown = {4'b0, s.secs} * 44'd10 + {36'b0, c - rap_pkg::CH_ZERO};
      if (grown > {4'b0, rap_pkg::SEC_LIMIT}) n.big = 1'b1;
      else n.secs = grown[rap_pkg::SecW-1:0];
    end
    return n;
  endfunction

  function automatic wait_res_t close_value(scan_t s);
    wait_res_t r;
    r.is_valid = (s.ph == rap_pkg::PH_DIGITS) || (s.ph == rap_pkg::PH_TRAIL);
    r.wait_ms  = '0;
    if (r.is_valid) begin
      r.wait_ms = s.big ? rap_pkg::WAIT_SAT_MS : {10'b0, s.secs} * 50'd1000;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      scan = ScanIdle;
      waits_due.delete();
    end else begin
      if (res_valid && res_ready) begin
        if (waits_due.size() == 0) begin
          $error("unexpected result item: is_valid=%0b wait_ms=%0d", res_is_valid, res_wait_ms);
          errs++;
        end else begin
          want = waits_due.pop_front();
          if (res_is_valid !== want.is_valid) begin
            $error("is_valid: expected %0b, got %0b", want.is_valid, res_is_valid);
            errs++;
          end
          if (res_wait_ms !== want.wait_ms) begin
            $error("wait_ms: expected %0d, got %0d", want.wait_ms, res_wait_ms);
            errs++;
          end
        end
      end
      if (hdr_valid && hdr_ready) begin
        // The empty flag closes the value without consuming the byte.
        if (!hdr_empty) scan = scan_byte(scan, hdr_byte);
        if (hdr_empty || hdr_last) begin
          waits_due.push_back(close_value(scan));
          scan = ScanIdle;
        end
      end
    end
    fail_count <= errs;
    pending    <= waits_due.size();
  end

endmodule

### tb/retry_after_seconds_parser_tb.sv
`timescale 1ns / 100ps
// Top of the Retry-After parser testbench: clock, reset, header stimulus and
// result back-pressure. Depends on rap_pkg, rap_if and the checker module.
module retry_after_seconds_parser_tb;

  localparam int WatchdogLimit = 5000;
  localparam int HoldCycles    = 300;
  localparam int PhaseItems    = 280;

  logic clk      = 1'b0;
  logic rst      = 1'b1;
  logic hold_req = 1'b0;
  int   gap_pct   = 0;
  int   stall_pct = 0;
  int   hdr_count = 0;
  int   fail_count;
  int   pending;

  rap_in_if  hdr_if ();
  rap_out_if res_if ();

  retry_after_seconds_parser dut (
    .clk (clk),
    .rst (rst),
    .hdr (hdr_if),
    .res (res_if)
  );

  retry_after_seconds_parser_checker chk (
    .clk          (clk),
    .rst          (rst),
    .hdr_valid    (hdr_if.valid),
    .hdr_ready    (hdr_if.ready),
    .hdr_byte     (hdr_if.byte_in),
    .hdr_last     (hdr_if.last_byte),
    .hdr_empty    (hdr_if.empty_value),
    .res_valid    (res_if.valid),
    .res_ready    (res_if.ready),
    .res_is_valid (res_if.is_valid),
    .res_wait_ms  (res_if.wait_ms),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Result side: random stalls, or one long hold-off on request.
  initial begin
    bit held;
    held = 1'b0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        res_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        res_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    int idle_run;
    idle_run = 0;
    while (idle_run < WatchdogLimit) begin
      @(posedge clk);
      if (rst || (hdr_if.valid && hdr_if.ready) || (res_if.valid && res_if.ready)) begin
        idle_run = 0;
      end else begin
        idle_run++;
      end
    end
    $display("Some tests failed");
    $finish;
  end

  task automatic put_hdr(input logic [7:0] b, input logic is_last, input logic is_empty);
    while ($urandom_range(99) < gap_pct) begin
      hdr_if.valid   <= 1'b0;
      hdr_if.byte_in <= 8'($urandom);
      @(posedge clk);
    end
    hdr_if.valid       <= 1'b1;
    hdr_if.byte_in     <= b;
    hdr_if.last_byte   <= is_last;
    hdr_if.empty_value <= is_empty;
    @(posedge clk);
    while (!hdr_if.ready) @(posedge clk);
    hdr_count++;
  endtask

  task automatic send_text(input string s, input logic closes);
    for (int i = 0; i < s.len(); i++) begin
      put_hdr(s[i], closes && (i == s.len() - 1), 1'b0);
    end
  endtask

  function automatic logic [7:0] blank();
    return $urandom_range(1) ? rap_pkg::CH_SPACE : rap_pkg::CH_TAB;
  endfunction

  // One header value: mostly well-formed with random digits, the rest broken.
  task automatic send_random_value();
    logic [7:0] txt[$];
    int         kind;
    int         n;
    kind = $urandom_range(99);
    if (kind >= 95) begin
      put_hdr(8'($urandom), 1'($urandom), 1'b1);
      return;
    end
    repeat ($urandom_range(3)) txt.push_back(blank());
    if (kind < 5) begin
      // exactly at the seconds cap, or one digit past it
      txt.push_back("1");
      repeat (12) txt.push_back(rap_pkg::CH_ZERO);
      if ($urandom_range(1)) txt.push_back(8'(rap_pkg::CH_ZERO + $urandom_range(9)));
    end else if (kind < 10) begin
      repeat (12 + $urandom_range(1)) txt.push_back(rap_pkg::CH_NINE);
    end else if (kind < 85 || kind >= 90) begin
      n = ($urandom_range(3) == 0) ? $urandom_range(7, 18) : $urandom_range(1, 5);
      repeat (n) txt.push_back(8'(rap_pkg::CH_ZERO + $urandom_range(9)));
    end
    repeat ($urandom_range(3)) txt.push_back(blank());
    if ($urandom_range(11) == 0) begin
      txt.push_back(blank());
      txt.push_back(8'(rap_pkg::CH_ZERO + $urandom_range(9)));
    end
    if ($urandom_range(5) == 0) txt.insert($urandom_range(txt.size()), 8'($urandom));
    if (txt.size() == 0) txt.push_back(blank());
    if (kind >= 90) begin
      // cut short: close with the empty flag instead of the last byte
      foreach (txt[i]) put_hdr(txt[i], 1'b0, 1'b0);
      put_hdr(8'($urandom), 1'($urandom), 1'b1);
    end else begin
      foreach (txt[i]) put_hdr(txt[i], i == txt.size() - 1, 1'b0);
    end
  endtask

  initial begin
    int goal;
    hdr_if.valid       = 1'b0;
    hdr_if.byte_in     = 8'h00;
    hdr_if.last_byte   = 1'b0;
    hdr_if.empty_value = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    put_hdr(8'hFF, 1'b1, 1'b1);
    send_text("\t7 ", 1'b1);
    send_text("0", 1'b1);
    send_text(" ", 1'b1);
    send_text("1 2", 1'b1);
    send_text(":", 1'b1);
    send_text("/", 1'b1);
    send_text("12", 1'b0);
    put_hdr(8'h00, 1'b0, 1'b1);
    send_text("1000000000001", 1'b1);

    goal = hdr_count;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 81; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 81; end
        default: begin gap_pct = 13; stall_pct = 13; end
      endcase
      goal += PhaseItems;
      while (hdr_count < goal) send_random_value();
    end

    // Hold the result side off while bytes keep coming, to fill the block.
    gap_pct   = 0;
    stall_pct = 0;
    hold_req <= 1'b1;
    repeat (12) send_random_value();

    hdr_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/rap_pkg.sv
rtl/rap_if.sv
rtl/rap_scan.sv
rtl/retry_after_seconds_parser.sv
tb/retry_after_seconds_parser_checker.sv
tb/retry_after_seconds_parser_tb.sv
